// ----- sv/bhpq_pkg.sv -----
`default_nettype none

package bhpq_pkg;

	// Default geometry of the queue.
	localparam int CAPACITY      = 256;
	localparam int KEY_WIDTH     = 32;
	localparam int PAYLOAD_WIDTH = 16;

	// Request command codes.
	localparam int CMD_W = 2;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;

	// Result status codes.
	localparam int STATUS_W = 2;
	localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

endpackage

`default_nettype wire

// ----- sv/bhpq_if.sv -----
`default_nettype none

// Request channel: one command with the entry to insert.
interface bhpq_req_if #(
	parameter int KEY_WIDTH     = bhpq_pkg::KEY_WIDTH,
	parameter int PAYLOAD_WIDTH = bhpq_pkg::PAYLOAD_WIDTH
);
	logic                           valid;
	logic                           ready;
	logic [bhpq_pkg::CMD_W-1:0]     cmd;
	logic [KEY_WIDTH-1:0]           new_key;
	logic [PAYLOAD_WIDTH-1:0]       new_payload;

	modport source (output valid, output cmd, output new_key, output new_payload,
		input ready);
	modport sink (input valid, input cmd, input new_key, input new_payload,
		output ready);
endinterface

// Result channel: status, reported entry and the count held afterwards.
interface bhpq_rsp_if #(
	parameter int KEY_WIDTH     = bhpq_pkg::KEY_WIDTH,
	parameter int PAYLOAD_WIDTH = bhpq_pkg::PAYLOAD_WIDTH,
	parameter int COUNT_WIDTH   = $clog2(bhpq_pkg::CAPACITY + 1)
);
	logic                           valid;
	logic                           ready;
	logic [bhpq_pkg::STATUS_W-1:0]  status;
	logic [KEY_WIDTH-1:0]           top_key;
	logic [PAYLOAD_WIDTH-1:0]       top_payload;
	logic [COUNT_WIDTH-1:0]         entry_count;

	modport source (output valid, output status, output top_key, output top_payload,
		output entry_count, input ready);
	modport sink (input valid, input status, input top_key, input top_payload,
		input entry_count, output ready);
endinterface

`default_nettype wire

// ----- sv/bhpq_store.sv -----
`default_nettype none

// Heap slot memory: one write port, one read port with registered read data.
module bhpq_store #(
	parameter int DEPTH = bhpq_pkg::CAPACITY,
	parameter int WIDTH = bhpq_pkg::KEY_WIDTH + bhpq_pkg::PAYLOAD_WIDTH
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- sv/binary_heap_priority_queue_top.sv -----
// Bounded binary-heap priority queue.
// Requests arrive on the req channel (valid/ready): cmd selects insert, remove
// of the top entry, or peek (the unused code also peeks). Each request gives
// exactly one transfer on the rsp channel with a status, the removed entry on
// a remove or else the current top entry (zero when none), and the count held.
// The cfg_wr_en/cfg_wr_data port sets the order: 0 smallest key first, 1 largest.
// One request is worked on at a time; req.ready is high only while no request
// is in progress. A peek, a rejected request or a remove that empties the queue
// goes straight to the output register; an insert fetches the parent of the
// new slot and moves parents down until the entry can be written; a remove
// fetches the last entry and sinks it from the root, each level reading the
// left and, if present, the right child from the memory, moving the better
// child up and then checking the next level.
// The result sits in an output register; if the receiver stalls, a finished
// result waits there and the next request may already be accepted and worked
// on, but it cannot complete until the waiting result has been taken.
// Reset empties the queue and selects smallest-first; no memory clearing is
// needed, since only slots below the count are ever read.
`default_nettype none

module binary_heap_priority_queue_top #(
	parameter int CAPACITY      = bhpq_pkg::CAPACITY,
	parameter int KEY_WIDTH     = bhpq_pkg::KEY_WIDTH,
	parameter int PAYLOAD_WIDTH = bhpq_pkg::PAYLOAD_WIDTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_wr_en,
	input  wire logic cfg_wr_data,
	bhpq_req_if.sink  req,
	bhpq_rsp_if.source rsp
);

	localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int IDX_W  = ADDR_W + 1;
	localparam int ENT_W  = KEY_WIDTH + PAYLOAD_WIDTH;

	localparam int ST_W = 3;
	localparam logic [ST_W-1:0] S_IDLE     = 3'd0;
	localparam logic [ST_W-1:0] S_UP_CMP   = 3'd1;
	localparam logic [ST_W-1:0] S_PUT      = 3'd2;
	localparam logic [ST_W-1:0] S_DN_LAST  = 3'd3;
	localparam logic [ST_W-1:0] S_DN_CHK   = 3'd4;
	localparam logic [ST_W-1:0] S_DN_LEFT  = 3'd5;
	localparam logic [ST_W-1:0] S_DN_RIGHT = 3'd6;
	localparam logic [ST_W-1:0] S_EMIT     = 3'd7;

	// True when key a must sit strictly above key b.
	function automatic logic ranks_above(input logic [KEY_WIDTH-1:0] a,
		input logic [KEY_WIDTH-1:0] b, input logic mode);
		return mode ? (a > b) : (a < b);
	endfunction

	logic [ST_W-1:0]              state_q, state_d;
	logic [CNT_W-1:0]             count_q, count_d;
	logic [ADDR_W-1:0]            pos_q, pos_d;
	logic [KEY_WIDTH-1:0]         ent_key_q, ent_key_d;
	logic [PAYLOAD_WIDTH-1:0]     ent_pay_q, ent_pay_d;
	logic [KEY_WIDTH-1:0]         lft_key_q, lft_key_d;
	logic [PAYLOAD_WIDTH-1:0]     lft_pay_q, lft_pay_d;
	logic [bhpq_pkg::STATUS_W-1:0] status_q, status_d;
	logic                         rep_q, rep_d;
	logic [KEY_WIDTH-1:0]         rkey_q, rkey_d;
	logic [PAYLOAD_WIDTH-1:0]     rpay_q, rpay_d;
	logic [KEY_WIDTH-1:0]         top_key_q;
	logic [PAYLOAD_WIDTH-1:0]     top_pay_q;
	logic                         order_q;

	logic                         out_valid_q;
	logic [bhpq_pkg::STATUS_W-1:0] out_status_q;
	logic [KEY_WIDTH-1:0]         out_key_q;
	logic [PAYLOAD_WIDTH-1:0]     out_pay_q;
	logic [CNT_W-1:0]             out_count_q;

	logic                         mem_wr_en, mem_rd_en;
	logic [ADDR_W-1:0]            mem_wr_addr, mem_rd_addr;
	logic [ENT_W-1:0]             mem_wr_data, mem_rd_data;
	logic [KEY_WIDTH-1:0]         rd_key;
	logic [PAYLOAD_WIDTH-1:0]     rd_pay;

	logic [IDX_W-1:0]             child_idx, right_idx, cnt_ext;
	logic [ADDR_W-1:0]            parent_idx, grand_idx;
	logic [CNT_W-1:0]             cnt_dec;
	logic                         right_better;
	logic [KEY_WIDTH-1:0]         best_key;
	logic [PAYLOAD_WIDTH-1:0]     best_pay;
	logic [ADDR_W-1:0]            best_idx;
	logic                         emit_go;
	logic                         accept;

	assign rd_key = mem_rd_data[ENT_W-1:PAYLOAD_WIDTH];
	assign rd_pay = mem_rd_data[PAYLOAD_WIDTH-1:0];

	bhpq_store #(
		.DEPTH (CAPACITY),
		.WIDTH (ENT_W)
	) u_store (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// Heap index arithmetic around the current hole position.
	assign child_idx  = {pos_q, 1'b1};
	assign right_idx  = child_idx + IDX_W'(1);
	assign cnt_ext    = IDX_W'(count_q);
	assign parent_idx = (pos_q - ADDR_W'(1)) >> 1;
	assign grand_idx  = (parent_idx - ADDR_W'(1)) >> 1;
	assign cnt_dec    = count_q - CNT_W'(1);

	// Pick the better child; on a tie the left child stays.
	assign right_better = ranks_above(rd_key, lft_key_q, order_q);
	always_comb begin
		best_key = rd_key;
		best_pay = rd_pay;
		best_idx = child_idx[ADDR_W-1:0];
		if (state_q == S_DN_RIGHT) begin
			if (right_better) begin
				best_idx = right_idx[ADDR_W-1:0];
			end else begin
				best_key = lft_key_q;
				best_pay = lft_pay_q;
			end
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && (state_q == S_IDLE);
	assign emit_go   = (state_q == S_EMIT) && (!out_valid_q || rsp.ready);

	// Sequencer: reads, compares and writes back one heap level at a time.
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		pos_d       = pos_q;
		ent_key_d   = ent_key_q;
		ent_pay_d   = ent_pay_q;
		lft_key_d   = lft_key_q;
		lft_pay_d   = lft_pay_q;
		status_d    = status_q;
		rep_d       = rep_q;
		rkey_d      = rkey_q;
		rpay_d      = rpay_q;
		mem_wr_en   = 1'b0;
		mem_wr_addr = pos_q;
		mem_wr_data = {ent_key_q, ent_pay_q};
		mem_rd_en   = 1'b0;
		mem_rd_addr = parent_idx;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					status_d = bhpq_pkg::STATUS_DONE;
					rep_d    = 1'b0;
					state_d  = S_EMIT;
					case (req.cmd)
						bhpq_pkg::CMD_INSERT: begin
							if (count_q == CNT_W'(CAPACITY)) begin
								status_d = bhpq_pkg::STATUS_FULL;
							end else begin
								ent_key_d = req.new_key;
								ent_pay_d = req.new_payload;
								pos_d     = count_q[ADDR_W-1:0];
								count_d   = count_q + CNT_W'(1);
								if (count_q == '0) begin
									state_d = S_PUT;
								end else begin
									// Fetch the parent of the new slot.
									mem_rd_en   = 1'b1;
									mem_rd_addr = (count_q[ADDR_W-1:0] - ADDR_W'(1)) >> 1;
									state_d     = S_UP_CMP;
								end
							end
						end
						bhpq_pkg::CMD_REMOVE: begin
							if (count_q == '0) begin
								status_d = bhpq_pkg::STATUS_EMPTY;
							end else begin
								rep_d   = 1'b1;
								rkey_d  = top_key_q;
								rpay_d  = top_pay_q;
								count_d = cnt_dec;
								if (cnt_dec != '0) begin
									// Fetch the last entry; it sinks from the root.
									mem_rd_en   = 1'b1;
									mem_rd_addr = cnt_dec[ADDR_W-1:0];
									state_d     = S_DN_LAST;
								end
							end
						end
						default: begin
							state_d = S_EMIT;
						end
					endcase
				end
			end
			S_UP_CMP: begin
				if (ranks_above(ent_key_q, rd_key, order_q)) begin
					// Parent moves down into the hole.
					mem_wr_en   = 1'b1;
					mem_wr_data = mem_rd_data;
					pos_d       = parent_idx;
					if (parent_idx == '0) begin
						state_d = S_PUT;
					end else begin
						mem_rd_en   = 1'b1;
						mem_rd_addr = grand_idx;
					end
				end else begin
					mem_wr_en = 1'b1;
					state_d   = S_EMIT;
				end
			end
			S_PUT: begin
				mem_wr_en = 1'b1;
				state_d   = S_EMIT;
			end
			S_DN_LAST: begin
				ent_key_d = rd_key;
				ent_pay_d = rd_pay;
				pos_d     = '0;
				state_d   = S_DN_CHK;
			end
			S_DN_CHK: begin
				if (child_idx >= cnt_ext) begin
					mem_wr_en = 1'b1;
					state_d   = S_EMIT;
				end else begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = child_idx[ADDR_W-1:0];
					state_d     = S_DN_LEFT;
				end
			end
			S_DN_LEFT, S_DN_RIGHT: begin
				lft_key_d = rd_key;
				lft_pay_d = rd_pay;
				if (state_q == S_DN_LEFT && right_idx < cnt_ext) begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = right_idx[ADDR_W-1:0];
					state_d     = S_DN_RIGHT;
				end else if (ranks_above(best_key, ent_key_q, order_q)) begin
					// Better child moves up into the hole.
					mem_wr_en   = 1'b1;
					mem_wr_data = {best_key, best_pay};
					pos_d       = best_idx;
					state_d     = S_DN_CHK;
				end else begin
					mem_wr_en = 1'b1;
					state_d   = S_EMIT;
				end
			end
			S_EMIT: begin
				if (emit_go) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			order_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (cfg_wr_en) begin
				order_q <= cfg_wr_data;
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers and the cached root entry.
	always_ff @(posedge clk) begin
		pos_q     <= pos_d;
		ent_key_q <= ent_key_d;
		ent_pay_q <= ent_pay_d;
		lft_key_q <= lft_key_d;
		lft_pay_q <= lft_pay_d;
		status_q  <= status_d;
		rep_q     <= rep_d;
		rkey_q    <= rkey_d;
		rpay_q    <= rpay_d;
		if (mem_wr_en && mem_wr_addr == '0) begin
			top_key_q <= mem_wr_data[ENT_W-1:PAYLOAD_WIDTH];
			top_pay_q <= mem_wr_data[PAYLOAD_WIDTH-1:0];
		end
	end

	// Output register loaded when the result can be handed over.
	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_status_q <= status_q;
			out_count_q  <= count_q;
			if (rep_q) begin
				out_key_q <= rkey_q;
				out_pay_q <= rpay_q;
			end else if (status_q != bhpq_pkg::STATUS_EMPTY && count_q != '0) begin
				out_key_q <= top_key_q;
				out_pay_q <= top_pay_q;
			end else begin
				out_key_q <= '0;
				out_pay_q <= '0;
			end
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.top_key     = out_key_q;
	assign rsp.top_payload = out_pay_q;
	assign rsp.entry_count = out_count_q;

endmodule

`default_nettype wire
